[sv/tcca_pkg.sv]
// Package for the two-class chunk allocator: payload structs, status codes,
// controller states and the reset contents of the link memory.
// No dependencies; every other file of the block uses it.
package tcca_pkg;

  localparam int HANDLES  = 32;
  localparam int HANDLE_W = 5;

  localparam logic [15:0] SMALL_LIMIT_RST = 16'd64;
  localparam logic [15:0] LARGE_LIMIT_RST = 16'd128;

  localparam logic CFG_SMALL_LIMIT = 1'b0;
  localparam logic CFG_LARGE_LIMIT = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FREED     = 3'd1;
  localparam logic [2:0] ST_NO_SMALL  = 3'd2;
  localparam logic [2:0] ST_NO_LARGE  = 3'd3;
  localparam logic [2:0] ST_SIZE_ERR  = 3'd4;

  typedef logic [HANDLE_W-1:0] handle_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] req_size;
    handle_t     chunk_handle;
  } cmd_t;

  typedef struct packed {
    handle_t    granted_handle;
    logic [2:0] status;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LINK
  } state_t;

  // Link of one entry right after reset: the small stack chains downward,
  // the large queue chains upward, and each list ends in a self-link.
  function automatic handle_t reset_link(handle_t idx, int s_end, int l_end);
    int i;
    handle_t link;
    i = int'(idx);
    if (i < s_end) begin
      link = (i == 0) ? '0 : HANDLE_W'(i - 1);
    end else if (i < l_end) begin
      link = (i + 1 < l_end) ? HANDLE_W'(i + 1) : idx;
    end else begin
      link = '0;
    end
    return link;
  endfunction

endpackage

[sv/two_class_chunk_allocator_unit.sv]
// Two-class chunk allocator: LIFO stack of small handles, FIFO queue of large.
// An allocate that pops a list reads the link memory and strobes done from the read state;
// a small free, a large free into an empty queue and any error strobe done from idle;
// a large free into a non-empty queue passes through the link state (two writes to the link memory).
// No new transaction is taken while busy in the read or link state, since the link memory has a
// single write port and a registered read. Synchronous reset rebuilds the lists at once.
module two_class_chunk_allocator_unit #(
  parameter int SMALL_COUNT = 16,
  parameter int LARGE_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcca_pkg::cmd_t    cmd,
  output logic              done,
  output tcca_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int SEnd = (SMALL_COUNT > tcca_pkg::HANDLES) ? tcca_pkg::HANDLES : SMALL_COUNT;
  localparam int LSum = SMALL_COUNT + LARGE_COUNT;
  localparam int LEnd = (LSum > tcca_pkg::HANDLES) ? tcca_pkg::HANDLES : LSum;
  localparam bit SmallEmptyRst = (SEnd == 0);
  localparam bit LargeEmptyRst = (LEnd <= SEnd);

  tcca_pkg::state_t state, state_next;
  tcca_pkg::handle_t small_top, small_top_next;
  logic small_empty, small_empty_next;
  tcca_pkg::handle_t large_head, large_head_next;
  tcca_pkg::handle_t large_tail, large_tail_next;
  logic large_empty, large_empty_next;
  logic [15:0] small_limit, large_limit;
  logic done_next;
  tcca_pkg::result_t result_next;
  tcca_pkg::handle_t pend_h, pend_h_next;
  logic pend_large, pend_large_next;

  logic mem_we, mem_re;
  tcca_pkg::handle_t mem_wa, mem_wd, mem_ra, rd_data;
  logic is_small_handle;

  tcca_link_mem #(
    .S_END(SEnd),
    .L_END(LEnd)
  ) u_link_mem (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (mem_we),
    .wr_addr(mem_wa),
    .wr_data(mem_wd),
    .rd_en  (mem_re),
    .rd_addr(mem_ra),
    .rd_data(rd_data)
  );

  assign busy      = (state != tcca_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign is_small_handle = (32'(cmd.chunk_handle) < SMALL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tcca_pkg::S_IDLE;
      small_top   <= SmallEmptyRst ? '0 : tcca_pkg::HANDLE_W'(SEnd - 1);
      small_empty <= SmallEmptyRst;
      large_head  <= LargeEmptyRst ? '0 : tcca_pkg::HANDLE_W'(SEnd);
      large_tail  <= LargeEmptyRst ? '0 : tcca_pkg::HANDLE_W'(LEnd - 1);
      large_empty <= LargeEmptyRst;
      small_limit <= tcca_pkg::SMALL_LIMIT_RST;
      large_limit <= tcca_pkg::LARGE_LIMIT_RST;
      done        <= 1'b0;
      pend_large  <= 1'b0;
    end else begin
      state       <= state_next;
      small_top   <= small_top_next;
      small_empty <= small_empty_next;
      large_head  <= large_head_next;
      large_tail  <= large_tail_next;
      large_empty <= large_empty_next;
      done        <= done_next;
      pend_large  <= pend_large_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcca_pkg::CFG_SMALL_LIMIT: small_limit <= cfg_data;
          tcca_pkg::CFG_LARGE_LIMIT: large_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    pend_h <= pend_h_next;
  end

  always_comb begin
    state_next       = state;
    small_top_next   = small_top;
    small_empty_next = small_empty;
    large_head_next  = large_head;
    large_tail_next  = large_tail;
    large_empty_next = large_empty;
    done_next        = 1'b0;
    result_next      = result;
    pend_h_next      = pend_h;
    pend_large_next  = pend_large;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;

    case (state)
      tcca_pkg::S_IDLE: begin
        if (start) begin
          if (cmd.operation == tcca_pkg::OP_FREE) begin
            if (is_small_handle) begin
              mem_we = 1'b1;
              mem_wa = cmd.chunk_handle;
              mem_wd = small_empty ? cmd.chunk_handle : small_top;
              small_top_next   = cmd.chunk_handle;
              small_empty_next = 1'b0;
              done_next   = 1'b1;
              result_next = '{granted_handle: '0, status: tcca_pkg::ST_FREED};
            end else if (large_empty) begin
              mem_we = 1'b1;
              mem_wa = cmd.chunk_handle;
              mem_wd = cmd.chunk_handle;
              large_head_next  = cmd.chunk_handle;
              large_tail_next  = cmd.chunk_handle;
              large_empty_next = 1'b0;
              done_next   = 1'b1;
              result_next = '{granted_handle: '0, status: tcca_pkg::ST_FREED};
            end else begin
              // Link the old tail now; the new tail's self-link follows.
              mem_we = 1'b1;
              mem_wa = large_tail;
              mem_wd = cmd.chunk_handle;
              pend_h_next = cmd.chunk_handle;
              state_next  = tcca_pkg::S_LINK;
            end
          end else if (cmd.req_size <= {16'b0, small_limit}) begin
            if (small_empty) begin
              done_next   = 1'b1;
              result_next = '{granted_handle: '0, status: tcca_pkg::ST_NO_SMALL};
            end else begin
              mem_re = 1'b1;
              mem_ra = small_top;
              pend_h_next     = small_top;
              pend_large_next = 1'b0;
              state_next      = tcca_pkg::S_READ;
            end
          end else if (cmd.req_size[15:0] < large_limit) begin
            if (large_empty) begin
              done_next   = 1'b1;
              result_next = '{granted_handle: '0, status: tcca_pkg::ST_NO_LARGE};
            end else begin
              mem_re = 1'b1;
              mem_ra = large_head;
              pend_h_next     = large_head;
              pend_large_next = 1'b1;
              state_next      = tcca_pkg::S_READ;
            end
          end else begin
            done_next   = 1'b1;
            result_next = '{granted_handle: '0, status: tcca_pkg::ST_SIZE_ERR};
          end
        end
      end

      tcca_pkg::S_READ: begin
        done_next   = 1'b1;
        result_next = '{granted_handle: pend_h, status: tcca_pkg::ST_ALLOCATED};
        if (!pend_large) begin
          // A self-linked top is the bottom of the stack.
          if (rd_data == pend_h) begin
            small_empty_next = 1'b1;
          end else begin
            small_top_next = rd_data;
          end
        end else begin
          if (pend_h == large_tail) begin
            large_empty_next = 1'b1;
          end else begin
            large_head_next = rd_data;
          end
        end
        state_next = tcca_pkg::S_IDLE;
      end

      tcca_pkg::S_LINK: begin
        mem_we = 1'b1;
        mem_wa = pend_h;
        mem_wd = pend_h;
        large_tail_next = pend_h;
        done_next   = 1'b1;
        result_next = '{granted_handle: '0, status: tcca_pkg::ST_FREED};
        state_next  = tcca_pkg::S_IDLE;
      end

      default: begin
        state_next = tcca_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[sv/tcca_link_mem.sv]
// Link memory of the allocator: one write port, one registered read port.
// Entries never written since reset read as their reset links via valid bits.
// Depends on tcca_pkg.
module tcca_link_mem #(
  parameter int S_END = 16,
  parameter int L_END = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  tcca_pkg::handle_t wr_addr,
  input  tcca_pkg::handle_t wr_data,
  input  logic             rd_en,
  input  tcca_pkg::handle_t rd_addr,
  output tcca_pkg::handle_t rd_data
);

  tcca_pkg::handle_t mem [tcca_pkg::HANDLES];
  logic [tcca_pkg::HANDLES-1:0] valid;
  tcca_pkg::handle_t rd_q;
  tcca_pkg::handle_t rd_rst_q;
  logic rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_rst_q <= tcca_pkg::reset_link(rd_addr, S_END, L_END);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : rd_rst_q;

endmodule

[sv/tcca_checker.sv]
// Port-level checks for the two-class chunk allocator, bound to the top level.
// Depends on tcca_pkg and two_class_chunk_allocator_unit.
module tcca_checker #(
  parameter int SMALL_COUNT = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input tcca_pkg::cmd_t    cmd,
  input logic              done,
  input tcca_pkg::result_t result
);

  logic accept;
  assign accept = start && !busy;

  // Every result strobe follows an accepted transaction.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(accept, 2)))
    else $error("result strobe without a recent transaction");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= tcca_pkg::ST_SIZE_ERR))
    else $error("status code out of range");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != tcca_pkg::ST_ALLOCATED)) |-> (result.granted_handle == '0))
    else $error("nonzero handle on a result that is not a grant");

  a_small_free: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.operation == tcca_pkg::OP_FREE) &&
     (32'(cmd.chunk_handle) < SMALL_COUNT))
    |=> (done && (result.status == tcca_pkg::ST_FREED) && !busy))
    else $error("small free did not complete in one cycle");

endmodule

bind two_class_chunk_allocator_unit tcca_checker #(
  .SMALL_COUNT(SMALL_COUNT)
) u_tcca_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done),
  .result(result)
);
